### design/rhss_pkg.sv
// rhss_pkg: shared types, constants and hash helpers for the rolling hash search
// used by rhss_ctrl, rhss_dp, rhss_chk and the top level
// no dependencies
package rhss_pkg;

    // default sizes
    localparam int MAX_PATTERN_DEF = 32;
    localparam int MAX_TEXT_DEF    = 65536;

    // hash arithmetic: base 26, modulo 997, residues fit 10 bits
    localparam int HASH_W    = 10;
    localparam int HASH_BASE = 26;
    localparam int HASH_MOD  = 997;
    // 2^HASH_W folded back under the modulus
    localparam int HASH_FOLD = (1 << HASH_W) % HASH_MOD;

    // stream widths
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PAT_ACCEPT,
        OP_PAT_REDUCE,
        OP_TXT_ACCEPT,
        OP_TXT_MUL,
        OP_TXT_ROLL,
        OP_TXT_PUSH,
        OP_CMP_READ,
        OP_CMP_EVAL,
        OP_EMIT
    } t_dp_op;

    // datapath status back to the controller
    typedef struct packed {
        logic hit;       // hash hit on the window just pushed, still to be confirmed
        logic cmp_done;  // full compare finished (mismatch or last pair)
        logic last;      // current beat closes the text
        logic out_busy;  // result register still holds an untaken beat
    } t_dp_status;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT_RED,
        ST_TXT_MUL,
        ST_TXT_ROLL,
        ST_TXT_PUSH,
        ST_CMP_RD,
        ST_CMP_EQ,
        ST_EMIT
    } t_state;

    // reduce an 18-bit value modulo 997 by two folds and one subtract
    function automatic logic [HASH_W-1:0] hash_mod(input logic [17:0] x);
        logic [12:0] y;
        logic [10:0] z;
        y = 13'(x[17:10]) * 13'(HASH_FOLD) + 13'(x[9:0]);
        z = 11'(y[12:10]) * 11'(HASH_FOLD) + 11'(y[9:0]);
        return (z >= 11'(HASH_MOD)) ? 10'(z - 11'(HASH_MOD)) : z[HASH_W-1:0];
    endfunction

    // h * 26 + b, unreduced
    function automatic logic [14:0] hash_shift(input logic [HASH_W-1:0] h,
                                               input logic [BYTE_W-1:0] b);
        return 15'(h) * 15'(HASH_BASE) + 15'(b);
    endfunction

endpackage

### design/rhss_ctrl.sv
// rhss_ctrl: sequencer for pattern load, window roll, full compare and result
// depends on rhss_pkg (t_state, t_dp_op, t_dp_status)
module rhss_ctrl
    import rhss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_req_type,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_op     o_op
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath operation
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type) begin
                        o_op    = OP_TXT_ACCEPT;
                        n_state = ST_TXT_MUL;
                    end else begin
                        o_op    = OP_PAT_ACCEPT;
                        n_state = ST_PAT_RED;
                    end
                end
            end
            ST_PAT_RED: begin
                o_op    = OP_PAT_REDUCE;
                n_state = ST_IDLE;
            end
            ST_TXT_MUL: begin
                o_op    = OP_TXT_MUL;
                n_state = ST_TXT_ROLL;
            end
            ST_TXT_ROLL: begin
                o_op    = OP_TXT_ROLL;
                n_state = ST_TXT_PUSH;
            end
            ST_TXT_PUSH: begin
                o_op = OP_TXT_PUSH;
                if (i_status.hit) begin
                    n_state = ST_CMP_RD;
                end else if (i_status.last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CMP_RD: begin
                o_op    = OP_CMP_READ;
                n_state = ST_CMP_EQ;
            end
            ST_CMP_EQ: begin
                o_op = OP_CMP_EVAL;
                if (!i_status.cmp_done) begin
                    n_state = ST_CMP_RD;
                end else if (i_status.last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // wait for a free result register
                if (!i_status.out_busy) begin
                    o_op    = OP_EMIT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### design/rhss_dp.sv
// rhss_dp: pattern and window stores, hash registers, counters, result register
// depends on rhss_pkg (hash_mod, hash_shift, t_dp_op, t_dp_status)
module rhss_dp
    import rhss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_op            i_op,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output logic              o_found,
    output logic [POS_W-1:0]  o_match_position,
    output logic              o_pattern_overflow
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = LW + 1;
    localparam int TW = $clog2(MAX_TEXT + 1);
    localparam int CW = ((TW > LW) ? TW : LW) + 1;

    // stores
    logic [BYTE_W-1:0] pat_mem [MAX_PATTERN];
    logic [BYTE_W-1:0] win_mem [MAX_PATTERN];
    logic [BYTE_W-1:0] r_pat_q;
    logic [BYTE_W-1:0] r_win_q;

    // pattern state
    logic [LW-1:0]     r_len;
    logic [HASH_W-1:0] r_ph;
    logic [HASH_W-1:0] r_drop;
    logic              r_ovf;
    logic              r_loading;
    logic [14:0]       r_ptmp;
    logic [14:0]       r_dtmp;
    logic              r_pstore;

    // text state
    logic [TW-1:0]     r_count;
    logic [HASH_W-1:0] r_wh;
    logic              r_match;
    logic [TW-1:0]     r_first;
    logic [AW-1:0]     r_wp;

    // per-beat working registers
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_act;
    logic              r_cnt_ok;
    logic              r_drop_en;
    logic [17:0]       r_prod;
    logic [AW-1:0]     r_cptr;
    logic [LW-1:0]     r_k;

    // result register
    logic              r_out_valid;
    logic              r_found;
    logic [POS_W-1:0]  r_pos;
    logic              r_out_ovf;

    // combinational helpers
    logic              eff_loading;
    logic [LW-1:0]     eff_len;
    logic [HASH_W-1:0] eff_ph;
    logic [HASH_W-1:0] eff_drop;
    logic [PW-1:0]     old_sum;
    logic [AW-1:0]     old_ptr;
    logic [AW-1:0]     start_ptr;
    logic [AW-1:0]     cptr_next;
    logic [AW-1:0]     wp_next;
    logic [HASH_W-1:0] sub_val;
    logic [10:0]       roll_sum;
    logic [HASH_W-1:0] wh_rolled;
    logic [HASH_W-1:0] wh_pushed;
    logic              hit;
    logic              pat_eq;
    logic              last_pair;
    logic              emit_found;
    logic [TW+15:0]    first_ext;
    logic              win_rd_en;
    logic [AW-1:0]     win_rd_addr;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(MAX_PATTERN - 1)) ? '0 : AW'(p + AW'(1));
    endfunction

    // effective pattern state: a fresh load starts from empty
    assign eff_loading = r_loading;
    assign eff_len     = eff_loading ? r_len : '0;
    assign eff_ph      = eff_loading ? r_ph : '0;
    assign eff_drop    = eff_loading ? r_drop : HASH_W'(1);

    // oldest window slot: (wp - len) mod ring size, compare starts one past it
    assign old_sum   = PW'(r_wp) + PW'(MAX_PATTERN) - PW'(r_len);
    assign old_ptr   = (old_sum >= PW'(MAX_PATTERN)) ?
                       AW'(old_sum - PW'(MAX_PATTERN)) : AW'(old_sum);
    assign start_ptr = ring_inc(old_ptr);
    assign cptr_next = ring_inc(r_cptr);
    assign wp_next   = ring_inc(r_wp);

    // drop the leaving byte, then shift in the new one
    assign sub_val   = hash_mod(r_prod);
    assign roll_sum  = 11'(r_wh) + 11'(HASH_MOD) - 11'(sub_val);
    assign wh_rolled = (roll_sum >= 11'(HASH_MOD)) ?
                       HASH_W'(roll_sum - 11'(HASH_MOD)) : HASH_W'(roll_sum);
    assign wh_pushed = hash_mod(18'(hash_shift(r_wh, r_byte)));

    // hash hit on a full window that still needs confirming
    assign hit = r_act && !r_match && (wh_pushed == r_ph) &&
                 (CW'(r_count) + CW'(1) >= CW'(r_len));

    // compare step
    assign pat_eq    = (r_win_q == r_pat_q);
    assign last_pair = (r_k == r_len);

    assign o_status.hit      = hit;
    assign o_status.cmp_done = !pat_eq || last_pair;
    assign o_status.last     = r_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // window read address: oldest byte on accept, compare pointer otherwise
    assign win_rd_en   = (i_op == OP_TXT_ACCEPT) || (i_op == OP_CMP_READ);
    assign win_rd_addr = (i_op == OP_TXT_ACCEPT) ? old_ptr : r_cptr;

    // pattern store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_op == OP_PAT_ACCEPT && eff_len < LW'(MAX_PATTERN)) begin
            pat_mem[eff_len[AW-1:0]] <= i_byte;
        end
        if (i_op == OP_CMP_READ) begin
            r_pat_q <= pat_mem[r_k[AW-1:0]];
        end
    end

    // window ring, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_op == OP_TXT_PUSH && r_act) begin
            win_mem[r_wp] <= r_byte;
        end
        if (win_rd_en) begin
            r_win_q <= win_mem[win_rd_addr];
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_PAT_ACCEPT: begin
                r_byte   <= i_byte;
                r_last   <= i_last;
                r_ptmp   <= hash_shift(eff_ph, i_byte);
                r_dtmp   <= (eff_len != '0) ? hash_shift(eff_drop, '0) : 15'(1);
                r_pstore <= (eff_len < LW'(MAX_PATTERN));
            end
            OP_TXT_ACCEPT: begin
                r_byte    <= i_byte;
                r_last    <= i_last;
                r_cnt_ok  <= (r_count < TW'(MAX_TEXT));
                r_act     <= (r_count < TW'(MAX_TEXT)) && !r_ovf && (r_len != '0);
                r_drop_en <= (CW'(r_count) >= CW'(r_len));
            end
            OP_TXT_MUL: begin
                r_prod <= 18'(r_win_q) * 18'(r_drop);
            end
            OP_TXT_PUSH: begin
                r_cptr <= start_ptr;
                r_k    <= '0;
            end
            OP_CMP_READ: begin
                r_cptr <= cptr_next;
                r_k    <= LW'(r_k + LW'(1));
            end
            default: begin
            end
        endcase
    end

    // pattern and text state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ph      <= '0;
            r_drop    <= HASH_W'(1);
            r_ovf     <= 1'b0;
            r_loading <= 1'b0;
            r_count   <= '0;
            r_wh      <= '0;
            r_match   <= 1'b0;
            r_first   <= '0;
            r_wp      <= '0;
        end else begin
            case (i_op)
                OP_PAT_ACCEPT: begin
                    r_loading <= !i_last;
                    if (!eff_loading) begin
                        // new pattern drops any text in progress
                        r_ovf   <= 1'b0;
                        r_count <= '0;
                        r_wh    <= '0;
                        r_match <= 1'b0;
                        r_first <= '0;
                        r_wp    <= '0;
                    end
                    if (eff_len >= LW'(MAX_PATTERN)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len <= LW'(eff_len + LW'(1));
                    end
                end
                OP_PAT_REDUCE: begin
                    if (r_pstore) begin
                        r_ph   <= hash_mod(18'(r_ptmp));
                        r_drop <= hash_mod(18'(r_dtmp));
                    end
                end
                OP_TXT_ACCEPT: begin
                    r_loading <= 1'b0;
                end
                OP_TXT_ROLL: begin
                    if (r_act && r_drop_en) begin
                        r_wh <= wh_rolled;
                    end
                end
                OP_TXT_PUSH: begin
                    if (r_cnt_ok) begin
                        r_count <= TW'(r_count + TW'(1));
                    end
                    if (r_act) begin
                        r_wh <= wh_pushed;
                        r_wp <= wp_next;
                    end
                end
                OP_CMP_EVAL: begin
                    if (pat_eq && last_pair) begin
                        r_match <= 1'b1;
                        r_first <= TW'(CW'(r_count) - CW'(r_len));
                    end
                end
                OP_EMIT: begin
                    // text state clears, pattern is kept
                    r_count <= '0;
                    r_wh    <= '0;
                    r_match <= 1'b0;
                    r_first <= '0;
                    r_wp    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // result values
    assign emit_found = !r_ovf && ((r_len == '0) || r_match);
    assign first_ext  = (TW + 16)'(r_first);

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT) begin
            r_found   <= emit_found;
            r_pos     <= (!r_ovf && (r_len != '0) && r_match) ? first_ext[15:0] : '0;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_match_position   = r_pos;
    assign o_pattern_overflow = r_out_ovf;

endmodule

### design/rolling_hash_substring_search_top.sv
// Rolling hash substring search, top level.
// Input stream: tuser = 0 loads a pattern byte, tuser = 1 feeds a text byte,
// tdata carries the byte, tlast closes the pattern or the text. The pattern
// is hashed as it loads (base 26, modulo 997); text bytes roll a window hash
// and fill a ring of the last MAX_PATTERN bytes.
// Output stream: one beat per text run, after the beat carrying tlast.
// Sequence: a pattern beat passes the accept and reduce states. A text beat
// passes accept, multiply, roll and push, set by the read of the leaving byte,
// its multiply by the drop power and the two dependent modular steps. A hash
// hit before the first match adds a read and an evaluate step per pattern byte
// for the full compare through the single read port of each store, ending early at
// the first unequal pair. The result beat is loaded in the emit state after the last text beat.
// One beat is worked on at a time; s_axis_tready is high only when idle.
// If the receiver stalls, the result register holds its beat; beats are still
// taken meanwhile until the next result is ready, which then holds the input off.
// Reset clears pattern length, hashes, counters and the result valid flag; the
// byte stores need no clearing since only written entries are read.
// depends on rhss_pkg, rhss_ctrl, rhss_dp
module rolling_hash_substring_search_top
    import rhss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,   // last
    input  logic                  s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] found, [16:1] match_position,
                                                  // [17] pattern_overflow, [23:18] zero
);

    t_dp_op           op;
    t_dp_status       status;
    logic             found;
    logic [POS_W-1:0] match_position;
    logic             pattern_overflow;

    // sequencer
    rhss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_op       (op)
    );

    // stores, hashes and result register
    rhss_dp #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .i_byte             (s_axis_tdata[BYTE_W-1:0]),
        .i_last             (s_axis_tlast),
        .i_out_ready        (m_axis_tready),
        .o_status           (status),
        .o_out_valid        (m_axis_tvalid),
        .o_found            (found),
        .o_match_position   (match_position),
        .o_pattern_overflow (pattern_overflow)
    );

    // result beat packing
    assign m_axis_tdata = {6'b0, pattern_overflow, match_position, found};

endmodule

### design/rhss_chk.sv
// rhss_chk: port-level checks on the rolling hash search, bound to the top level
// depends on rhss_pkg and rolling_hash_substring_search_top
module rhss_chk
    import rhss_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // each accepted beat leaves the block busy in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no match reports position zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
        else $error("nonzero position without a match");

    // an overlong pattern never matches
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[0])
        else $error("match reported for an overlong pattern");

endmodule

bind rolling_hash_substring_search_top rhss_chk u_rhss_chk (.*);
